// ===== rtl/dual_motor_slew_limiter_with_watchdog_defines.svh =====
// assertion macros used by the checker file
`ifndef DUAL_MOTOR_SLEW_LIMITER_WITH_WATCHDOG_DEFINES_SVH
`define DUAL_MOTOR_SLEW_LIMITER_WITH_WATCHDOG_DEFINES_SVH

// same-cycle implication, off during reset
`define DMSL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dmsl assertion failed");

// next-cycle implication, off during reset
`define DMSL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dmsl assertion failed");

`endif

// ===== rtl/dmsl_pkg.sv =====
package dmsl_pkg;

    localparam int CHANNELS_DEF = 2;

    localparam int MODE_W    = 2;
    localparam int NOW_W     = 32;
    localparam int SPEED_W   = 16;
    localparam int CTRL_W    = 11;
    localparam int DRIVE_W   = 10;
    localparam int TIMEOUT_W = 16;
    localparam int DWELL_W   = 16;
    localparam int STEP_W    = 10;
    localparam int LIMIT_W   = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // input tdata layout
    localparam int S_NOW_LSB   = 0;
    localparam int S_OK_BIT    = S_NOW_LSB + NOW_W;
    localparam int S_LEFT_LSB  = S_OK_BIT + 1;
    localparam int S_RIGHT_LSB = S_LEFT_LSB + SPEED_W;
    localparam int S_USED_W    = S_RIGHT_LSB + SPEED_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // result tdata layout
    localparam int M_ACC_BIT  = 0;
    localparam int M_DW_BIT   = 1;
    localparam int M_LF_LSB   = 2;
    localparam int M_LR_LSB   = M_LF_LSB + DRIVE_W;
    localparam int M_RF_LSB   = M_LR_LSB + DRIVE_W;
    localparam int M_RR_LSB   = M_RF_LSB + DRIVE_W;
    localparam int M_USED_W   = M_RR_LSB + DRIVE_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd250;
    localparam logic [DWELL_W-1:0]   DWELL_RST   = 16'd50;
    localparam logic [STEP_W-1:0]    STEP_RST    = 10'd35;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 10'd1000;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 2'd0,
        MODE_ARM     = 2'd1,
        MODE_COMMAND = 2'd2,
        MODE_STOP    = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_DWELL   = 2'd1,
        CFG_STEP    = 2'd2,
        CFG_LIMIT   = 2'd3
    } cfg_idx_t;

endpackage

// ===== rtl/dual_motor_slew_limiter_with_watchdog.sv =====
// Slew-limited drive for two motor channels with a command watchdog.
// Input channel s_*: one event per transfer (tick, arm, command, stop) with a
// timestamp, a health flag and two signed commanded speeds.
// Result channel m_*: exactly one result per event: accepted flag,
// drive_written flag and forward/reverse drive magnitudes of both channels.
// Configuration channel cfg_*: register index and data, always ready; write
// only while no event is in flight.
// An event passes the input register, then the result register, before it
// shows on m_tvalid. One event per cycle while m_tready is not held low; the
// whole state update is a single pass of logic between the two registers.
// Reset (aresetn low, synchronous): disarmed, no fault, all targets and drive
// levels zero, registers back to timeout 250, dwell 50, step 35, limit 1000.
// When the receiver stalls, the result register holds and one more event is
// held in the input register; s_tready then drops until m_tready returns.
module dual_motor_slew_limiter_with_watchdog
    import dmsl_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now, ok, left_speed, right_speed, zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [MODE_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // accepted, drive_written, left_forward, left_reverse, right_forward,
    // right_reverse, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int REP_CH = 2;

    // configuration
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [DWELL_W-1:0]   dwell_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    // input register
    logic                      in_valid_reg;
    mode_t                     in_mode_reg;
    logic [NOW_W-1:0]          in_now_reg;
    logic                      in_ok_reg;
    logic signed [SPEED_W-1:0] in_left_reg;
    logic signed [SPEED_W-1:0] in_right_reg;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    // block state
    logic                     armed_reg, armed_next;
    logic                     fault_reg, fault_next;
    logic signed [CTRL_W-1:0] target_reg [CHANNELS];
    logic signed [CTRL_W-1:0] target_next [CHANNELS];
    logic signed [CTRL_W-1:0] pout_reg [CHANNELS];
    logic signed [CTRL_W-1:0] pout_next [CHANNELS];
    logic                     pend_reg [CHANNELS];
    logic                     pend_next [CHANNELS];
    logic [NOW_W-1:0]         zrt_reg [CHANNELS];
    logic [NOW_W-1:0]         zrt_next [CHANNELS];
    logic [NOW_W-1:0]         lct_reg, lct_next;

    // per-channel slew results
    logic signed [CTRL_W-1:0] slew_out [CHANNELS];
    logic                     slew_pend [CHANNELS];
    logic                     slew_mark [CHANNELS];

    logic advance;
    logic process;

    assign advance   = !out_valid_reg || m_tready;
    assign process   = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RST;
            dwell_reg   <= DWELL_RST;
            step_reg    <= STEP_RST;
            limit_reg   <= LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_DWELL:   dwell_reg   <= cfg_data[DWELL_W-1:0];
                CFG_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                CFG_LIMIT:   limit_reg   <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg  <= mode_t'(s_tuser);
            in_now_reg   <= s_tdata[S_NOW_LSB +: NOW_W];
            in_ok_reg    <= s_tdata[S_OK_BIT];
            in_left_reg  <= s_tdata[S_LEFT_LSB +: SPEED_W];
            in_right_reg <= s_tdata[S_RIGHT_LSB +: SPEED_W];
        end
    end

    // slew toward target, reversal through zero with dwell
    always_comb begin
        logic signed [CTRL_W-1:0] o;
        logic signed [CTRL_W-1:0] t;
        logic signed [CTRL_W:0]   up;
        logic signed [CTRL_W:0]   dn;
        logic signed [CTRL_W:0]   te;
        logic signed [CTRL_W-1:0] nv;
        logic                     o_pos, o_neg, t_pos, t_neg, rev, held;
        logic [NOW_W-1:0]         since;
        for (int i = 0; i < CHANNELS; i++) begin
            o     = pout_reg[i];
            o_neg = o[CTRL_W-1];
            o_pos = !o[CTRL_W-1] && (o != '0);
            t_neg = target_reg[i][CTRL_W-1];
            t_pos = !target_reg[i][CTRL_W-1] && (target_reg[i] != '0);
            rev   = (o_pos && t_neg) || (o_neg && t_pos);
            t     = rev ? '0 : target_reg[i];
            since = in_now_reg - zrt_reg[i];
            held  = pend_reg[i] && (since < {{(NOW_W-DWELL_W){1'b0}}, dwell_reg});
            te    = {t[CTRL_W-1], t};
            up    = {o[CTRL_W-1], o} + {{(CTRL_W+1-STEP_W){1'b0}}, step_reg};
            dn    = {o[CTRL_W-1], o} - {{(CTRL_W+1-STEP_W){1'b0}}, step_reg};
            if (o < t) begin
                nv = (up > te) ? t : up[CTRL_W-1:0];
            end else if (o > t) begin
                nv = (dn < te) ? t : dn[CTRL_W-1:0];
            end else begin
                nv = o;
            end
            if (held) begin
                slew_out[i]  = o;
                slew_pend[i] = 1'b1;
                slew_mark[i] = 1'b0;
            end else begin
                slew_out[i]  = nv;
                slew_pend[i] = rev && (nv == '0);
                slew_mark[i] = rev && (nv == '0);
            end
        end
    end

    always_comb begin
        logic signed [SPEED_W:0]  lim_pos, lim_neg, left_x, right_x;
        logic                     in_range, idle, timed_out, acc, dw;
        logic signed [CTRL_W-1:0] rep [REP_CH];
        logic [CTRL_W-1:0]        mag [REP_CH];
        logic [DRIVE_W-1:0]       fwd [REP_CH];
        logic [DRIVE_W-1:0]       rvs [REP_CH];

        armed_next = armed_reg;
        fault_next = fault_reg;
        lct_next   = lct_reg;
        for (int i = 0; i < CHANNELS; i++) begin
            target_next[i] = target_reg[i];
            pout_next[i]   = pout_reg[i];
            pend_next[i]   = pend_reg[i];
            zrt_next[i]    = zrt_reg[i];
        end

        lim_pos   = {{(SPEED_W+1-LIMIT_W){1'b0}}, limit_reg};
        lim_neg   = -lim_pos;
        left_x    = {in_left_reg[SPEED_W-1], in_left_reg};
        right_x   = {in_right_reg[SPEED_W-1], in_right_reg};
        in_range  = (left_x >= lim_neg) && (left_x <= lim_pos) &&
                    (right_x >= lim_neg) && (right_x <= lim_pos);
        idle = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            if (pout_reg[i] != '0) begin
                idle = 1'b0;
            end
        end
        timed_out = armed_reg &&
                    ((in_now_reg - lct_reg) >= {{(NOW_W-TIMEOUT_W){1'b0}}, timeout_reg});
        acc = 1'b0;
        dw  = 1'b0;

        if (process) begin
            unique case (in_mode_reg)
                MODE_STOP: begin
                    dw         = 1'b1;
                    armed_next = 1'b0;
                    fault_next = 1'b1;
                    for (int i = 0; i < CHANNELS; i++) begin
                        target_next[i] = '0;
                        pout_next[i]   = '0;
                        pend_next[i]   = 1'b0;
                    end
                end
                MODE_ARM: begin
                    if (in_ok_reg && !armed_reg && idle) begin
                        acc        = 1'b1;
                        fault_next = 1'b0;
                        armed_next = 1'b1;
                        lct_next   = in_now_reg;
                        for (int i = 0; i < CHANNELS; i++) begin
                            target_next[i] = '0;
                        end
                    end
                end
                MODE_COMMAND: begin
                    if (armed_reg && !fault_reg && in_range) begin
                        acc      = 1'b1;
                        lct_next = in_now_reg;
                        for (int i = 0; i < CHANNELS; i++) begin
                            if (i == 0) begin
                                target_next[i] = in_left_reg[CTRL_W-1:0];
                            end else if (i == 1) begin
                                target_next[i] = in_right_reg[CTRL_W-1:0];
                            end else begin
                                target_next[i] = '0;
                            end
                        end
                    end
                end
                MODE_TICK: begin
                    dw = 1'b1;
                    if (!in_ok_reg || timed_out) begin
                        armed_next = 1'b0;
                        fault_next = 1'b1;
                        for (int i = 0; i < CHANNELS; i++) begin
                            target_next[i] = '0;
                            pout_next[i]   = '0;
                            pend_next[i]   = 1'b0;
                        end
                    end else if (!armed_reg || fault_reg) begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            pout_next[i] = '0;
                        end
                    end else begin
                        for (int i = 0; i < CHANNELS; i++) begin
                            pout_next[i] = slew_out[i];
                            pend_next[i] = slew_pend[i];
                            if (slew_mark[i]) begin
                                zrt_next[i] = in_now_reg;
                            end
                        end
                    end
                end
            endcase
        end

        for (int c = 0; c < REP_CH; c++) begin
            rep[c] = '0;
        end
        for (int c = 0; c < REP_CH && c < CHANNELS; c++) begin
            rep[c] = dw ? pout_next[c] : '0;
        end
        for (int c = 0; c < REP_CH; c++) begin
            mag[c] = -rep[c];
            fwd[c] = (!rep[c][CTRL_W-1]) ? rep[c][DRIVE_W-1:0] : '0;
            rvs[c] = rep[c][CTRL_W-1] ? mag[c][DRIVE_W-1:0] : '0;
        end

        out_data_next = '0;
        out_data_next[M_ACC_BIT]               = acc;
        out_data_next[M_DW_BIT]                = dw;
        out_data_next[M_LF_LSB +: DRIVE_W]     = fwd[0];
        out_data_next[M_LR_LSB +: DRIVE_W]     = rvs[0];
        out_data_next[M_RF_LSB +: DRIVE_W]     = fwd[1];
        out_data_next[M_RR_LSB +: DRIVE_W]     = rvs[1];

        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            armed_reg     <= 1'b0;
            fault_reg     <= 1'b0;
            lct_reg       <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                target_reg[i] <= '0;
                pout_reg[i]   <= '0;
                pend_reg[i]   <= 1'b0;
                zrt_reg[i]    <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            armed_reg     <= armed_next;
            fault_reg     <= fault_next;
            lct_reg       <= lct_next;
            for (int i = 0; i < CHANNELS; i++) begin
                target_reg[i] <= target_next[i];
                pout_reg[i]   <= pout_next[i];
                pend_reg[i]   <= pend_next[i];
                zrt_reg[i]    <= zrt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/dmsl_checker.sv =====
`include "dual_motor_slew_limiter_with_watchdog_defines.svh"

module dmsl_checker
    import dmsl_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `DMSL_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    `DMSL_ASSERT_IMPL(a_flags_exclusive, aclk, aresetn, m_tvalid, !(m_tdata[M_ACC_BIT] && m_tdata[M_DW_BIT]))

    `DMSL_ASSERT_IMPL(a_no_drive_on_control, aclk, aresetn, m_tvalid && !m_tdata[M_DW_BIT], m_tdata[M_TDATA_W-1:M_LF_LSB] == '0)

    `DMSL_ASSERT_IMPL(a_one_direction, aclk, aresetn, m_tvalid, (m_tdata[M_LF_LSB +: DRIVE_W] == '0 || m_tdata[M_LR_LSB +: DRIVE_W] == '0) && (m_tdata[M_RF_LSB +: DRIVE_W] == '0 || m_tdata[M_RR_LSB +: DRIVE_W] == '0))

endmodule

bind dual_motor_slew_limiter_with_watchdog dmsl_checker u_dmsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
